### hw/rtl/hrt_pkg.sv
`default_nettype none
package hrt_pkg;

    localparam int HRT_MAX_LINE = 8192;
    localparam int HRT_Q_DEPTH  = 4;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_REQ_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HDR_LIMIT = 2'd1;

    localparam logic [CFG_W-1:0] REQ_LIMIT_RST = 13'd1023;
    localparam logic [CFG_W-1:0] HDR_LIMIT_RST = 13'd8191;

    localparam logic [7:0] CHR_CR    = 8'h0d;
    localparam logic [7:0] CHR_LF    = 8'h0a;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_COLON = 8'h3a;
    localparam logic [7:0] CHR_NUL   = 8'h00;
    localparam logic [7:0] CHR_UC_A  = 8'h41;
    localparam logic [7:0] CHR_UC_Z  = 8'h5a;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    localparam logic [2:0] KIND_METHOD   = 3'd0;
    localparam logic [2:0] KIND_URI      = 3'd1;
    localparam logic [2:0] KIND_VERSION  = 3'd2;
    localparam logic [2:0] KIND_NAME     = 3'd3;
    localparam logic [2:0] KIND_VALUE    = 3'd4;
    localparam logic [2:0] KIND_REQ_DONE = 3'd5;
    localparam logic [2:0] KIND_HDR_DONE = 3'd6;
    localparam logic [2:0] KIND_ERROR    = 3'd7;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_CR_NOLF = 3'd1;
    localparam logic [2:0] ERR_LONG    = 3'd2;
    localparam logic [2:0] ERR_END     = 3'd3;
    localparam logic [2:0] ERR_BAD_REQ = 3'd4;
    localparam logic [2:0] ERR_CONT    = 3'd5;
    localparam logic [2:0] ERR_COLON   = 3'd6;

    typedef enum logic [3:0] {
        CLS_OTHER,
        CLS_CR,
        CLS_LF,
        CLS_ZERO,
        CLS_SPACE,
        CLS_TAB,
        CLS_COLON,
        CLS_END,
        CLS_RESTART
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [7:0] data;
        logic [7:0] lc;
    } t_tok;

endpackage
`default_nettype wire

### hw/rtl/hrt_if.sv
`default_nettype none
interface hrt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       stream_end;
    logic       restart;

    modport source (output valid, output rx_byte, output stream_end, output restart,
                    input ready);
    modport sink   (input valid, input rx_byte, input stream_end, input restart,
                    output ready);
endinterface

interface hrt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       new_header;
    logic [2:0] error_code;

    modport source (output valid, output kind, output data_byte, output new_header,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input data_byte, input new_header,
                    input error_code, output ready);
endinterface

interface hrt_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [12:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/hrt_front.sv
`default_nettype none
module hrt_front (
    hrt_in_if.sink          i_rx,
    input  wire logic       i_q_full,
    output hrt_pkg::t_tok   o_tok,
    output logic            o_push
);
    import hrt_pkg::*;

    t_cls w_cls;

    always_comb begin
        if (i_rx.restart) begin
            w_cls = CLS_RESTART;
        end else if (i_rx.stream_end) begin
            w_cls = CLS_END;
        end else begin
            case (i_rx.rx_byte)
                CHR_CR:    w_cls = CLS_CR;
                CHR_LF:    w_cls = CLS_LF;
                CHR_NUL:   w_cls = CLS_ZERO;
                CHR_SPACE: w_cls = CLS_SPACE;
                CHR_TAB:   w_cls = CLS_TAB;
                CHR_COLON: w_cls = CLS_COLON;
                default:   w_cls = CLS_OTHER;
            endcase
        end
    end

    assign i_rx.ready = !i_q_full;
    assign o_push     = i_rx.valid && !i_q_full;

    always_comb begin
        o_tok.cls  = w_cls;
        o_tok.data = i_rx.rx_byte;
        if (i_rx.rx_byte >= CHR_UC_A && i_rx.rx_byte <= CHR_UC_Z) begin
            o_tok.lc = i_rx.rx_byte | CASE_BIT;
        end else begin
            o_tok.lc = i_rx.rx_byte;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/hrt_queue.sv
`default_nettype none
module hrt_queue #(
    parameter int DEPTH = hrt_pkg::HRT_Q_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire hrt_pkg::t_tok i_tok,
    output logic               o_full,
    output logic               o_valid,
    output hrt_pkg::t_tok      o_tok,
    input  wire logic          i_pop
);
    import hrt_pkg::*;

    localparam int PW = $clog2(DEPTH);

    t_tok          r_mem [DEPTH];
    logic [PW-1:0] r_wptr;
    logic [PW-1:0] r_rptr;
    logic [PW:0]   r_cnt;
    logic          w_push;
    logic          w_pop;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_tok   = r_mem[r_rptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + (PW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (PW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(DEPTH))
        else $error("queue count beyond depth");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == (PW+1)'(DEPTH)) |-> (r_wptr == r_rptr))
        else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

### hw/rtl/hrt_back.sv
`default_nettype none
module hrt_back #(
    parameter int MAX_LINE = hrt_pkg::HRT_MAX_LINE
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire hrt_pkg::t_tok            i_q_tok,
    output logic                          o_q_pop,
    input  wire logic [hrt_pkg::CFG_W-1:0] i_req_limit,
    input  wire logic [hrt_pkg::CFG_W-1:0] i_hdr_limit,
    hrt_out_if.source                     o_tok
);
    import hrt_pkg::*;

    localparam int LW = $clog2(MAX_LINE);
    localparam logic [CFG_W-1:0] LIM_MAX = CFG_W'(MAX_LINE - 1);

    typedef enum logic [3:0] {
        M_METHOD  = 4'd0,
        M_URI     = 4'd1,
        M_VERSION = 4'd2,
        M_HSTART  = 4'd3,
        M_HNAME   = 4'd4,
        M_HSKIP   = 4'd5,
        M_HVALUE  = 4'd6,
        M_BADCONT = 4'd7,
        M_NOCOLON = 4'd8,
        M_BLANK   = 4'd9,
        M_DONE    = 4'd10,
        M_FAILED  = 4'd11
    } t_mode;

    t_mode         r_mode, n_mode;
    logic          r_cr, n_cr;
    logic [LW-1:0] r_len, n_len;
    logic          r_any, n_any;
    logic          r_cut, n_cut;
    logic          r_pend, n_pend;

    logic          r_ovalid;
    logic [2:0]    r_kind, n_kind;
    logic [7:0]    r_data, n_data;
    logic          r_nh, n_nh;
    logic [2:0]    r_err, n_err;
    logic          n_emit;

    logic [CFG_W-1:0] w_lim_raw;
    logic [CFG_W-1:0] w_lim;
    logic             w_ws;
    logic [2:0]       w_req_kind;

    assign o_q_pop = i_q_valid && (!r_ovalid || o_tok.ready);

    assign w_lim_raw = (r_mode == M_METHOD || r_mode == M_URI || r_mode == M_VERSION)
                       ? i_req_limit : i_hdr_limit;
    assign w_lim     = (w_lim_raw > LIM_MAX) ? LIM_MAX : w_lim_raw;
    assign w_ws      = (i_q_tok.cls == CLS_SPACE) || (i_q_tok.cls == CLS_TAB);

    always_comb begin
        case (r_mode)
            M_URI:     w_req_kind = KIND_URI;
            M_VERSION: w_req_kind = KIND_VERSION;
            default:   w_req_kind = KIND_METHOD;
        endcase
    end

    always_comb begin
        n_mode = r_mode;
        n_cr   = r_cr;
        n_len  = r_len;
        n_any  = r_any;
        n_cut  = r_cut;
        n_pend = r_pend;
        n_emit = 1'b0;
        n_kind = KIND_METHOD;
        n_data = '0;
        n_nh   = 1'b0;
        n_err  = ERR_NONE;

        if (o_q_pop) begin
            if (i_q_tok.cls == CLS_RESTART) begin
                n_mode = M_METHOD;
                n_cr   = 1'b0;
                n_len  = '0;
                n_any  = 1'b0;
                n_cut  = 1'b0;
                n_pend = 1'b0;
            end else if (r_mode == M_DONE || r_mode == M_FAILED) begin
                n_mode = r_mode;
            end else if (i_q_tok.cls == CLS_END) begin
                n_mode = M_FAILED;
                n_emit = 1'b1;
                n_kind = KIND_ERROR;
                n_err  = r_cr ? ERR_CR_NOLF : ERR_END;
            end else if (r_cr) begin
                n_cr = 1'b0;
                if (i_q_tok.cls == CLS_LF) begin
                    n_len  = '0;
                    n_cut  = 1'b0;
                    n_pend = 1'b0;
                    case (r_mode)
                        M_METHOD: begin
                            n_mode = M_FAILED;
                            n_emit = 1'b1;
                            n_kind = KIND_ERROR;
                            n_err  = ERR_BAD_REQ;
                        end
                        M_URI, M_VERSION: begin
                            n_mode = M_HSTART;
                            n_emit = 1'b1;
                            n_kind = KIND_REQ_DONE;
                        end
                        M_HSTART, M_BLANK: begin
                            n_mode = M_DONE;
                            n_emit = 1'b1;
                            n_kind = KIND_HDR_DONE;
                        end
                        M_HNAME, M_NOCOLON: begin
                            n_mode = M_FAILED;
                            n_emit = 1'b1;
                            n_kind = KIND_ERROR;
                            n_err  = ERR_COLON;
                        end
                        M_BADCONT: begin
                            n_mode = M_FAILED;
                            n_emit = 1'b1;
                            n_kind = KIND_ERROR;
                            n_err  = ERR_CONT;
                        end
                        default: begin
                            n_mode = M_HSTART;
                        end
                    endcase
                end else begin
                    n_mode = M_FAILED;
                    n_emit = 1'b1;
                    n_kind = KIND_ERROR;
                    n_err  = ERR_CR_NOLF;
                end
            end else if (i_q_tok.cls == CLS_CR) begin
                n_cr = 1'b1;
            end else if (CFG_W'(r_len) >= w_lim) begin
                n_mode = M_FAILED;
                n_emit = 1'b1;
                n_kind = KIND_ERROR;
                n_err  = ERR_LONG;
            end else begin
                n_len = r_len + LW'(1);
                case (r_mode)
                    M_METHOD, M_URI, M_VERSION: begin
                        if (r_cut) begin
                            n_cut = 1'b1;
                        end else if (i_q_tok.cls == CLS_ZERO) begin
                            n_cut = 1'b1;
                        end else if (i_q_tok.cls == CLS_SPACE && r_mode != M_VERSION) begin
                            n_mode = (r_mode == M_METHOD) ? M_URI : M_VERSION;
                        end else begin
                            n_emit = 1'b1;
                            n_kind = w_req_kind;
                            n_data = i_q_tok.data;
                        end
                    end
                    M_HSTART: begin
                        if (i_q_tok.cls == CLS_ZERO) begin
                            n_mode = M_BLANK;
                        end else if (w_ws) begin
                            if (!r_any) begin
                                n_mode = M_BADCONT;
                            end else begin
                                n_mode = M_HVALUE;
                                n_emit = 1'b1;
                                n_kind = KIND_VALUE;
                                n_data = i_q_tok.data;
                            end
                        end else if (i_q_tok.cls == CLS_COLON) begin
                            n_any  = 1'b1;
                            n_pend = 1'b1;
                            n_mode = M_HSKIP;
                        end else begin
                            n_mode = M_HNAME;
                            n_emit = 1'b1;
                            n_kind = KIND_NAME;
                            n_data = i_q_tok.lc;
                            n_nh   = 1'b1;
                        end
                    end
                    M_HNAME: begin
                        if (i_q_tok.cls == CLS_COLON) begin
                            n_any  = 1'b1;
                            n_mode = M_HSKIP;
                        end else if (i_q_tok.cls == CLS_ZERO) begin
                            n_mode = M_NOCOLON;
                        end else begin
                            n_emit = 1'b1;
                            n_kind = KIND_NAME;
                            n_data = i_q_tok.lc;
                        end
                    end
                    M_HSKIP: begin
                        if (!w_ws) begin
                            n_mode = M_HVALUE;
                            if (i_q_tok.cls == CLS_ZERO) begin
                                n_cut = 1'b1;
                            end else begin
                                n_pend = 1'b0;
                                n_emit = 1'b1;
                                n_kind = KIND_VALUE;
                                n_data = i_q_tok.data;
                                n_nh   = r_pend;
                            end
                        end
                    end
                    M_HVALUE: begin
                        if (r_cut || i_q_tok.cls == CLS_ZERO) begin
                            n_cut = 1'b1;
                        end else begin
                            n_emit = 1'b1;
                            n_kind = KIND_VALUE;
                            n_data = i_q_tok.data;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= M_METHOD;
            r_cr     <= 1'b0;
            r_len    <= '0;
            r_any    <= 1'b0;
            r_cut    <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_cr   <= n_cr;
            r_len  <= n_len;
            r_any  <= n_any;
            r_cut  <= n_cut;
            r_pend <= n_pend;
            if (o_q_pop) begin
                r_ovalid <= n_emit;
            end else if (o_tok.ready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (o_q_pop && n_emit) begin
            r_kind <= n_kind;
            r_data <= n_data;
            r_nh   <= n_nh;
            r_err  <= n_err;
        end
    end

    assign o_tok.valid      = r_ovalid;
    assign o_tok.kind       = r_kind;
    assign o_tok.data_byte  = r_data;
    assign o_tok.new_header = r_nh;
    assign o_tok.error_code = r_err;

    a_len_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CFG_W'(r_len) <= LIM_MAX)
        else $error("line length beyond cap");

    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ((r_kind == KIND_ERROR) == (r_err != ERR_NONE)))
        else $error("error code inconsistent with kind");

    a_new_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_nh) |-> (r_kind == KIND_NAME || r_kind == KIND_VALUE))
        else $error("new header mark on non-header item");

endmodule
`default_nettype wire

### hw/rtl/http_request_header_tokenizer.sv
`default_nettype none
// HTTP request header tokenizer. Takes one byte per cycle on i_rx and emits
// tagged tokens on o_tok: method, uri and version bytes, lowercased header
// name bytes, value bytes, request-line-done, headers-done and error items.
// Input is accepted every cycle while the 4-entry token queue between the
// classifier and the parser has room; the parser drains one entry per cycle
// into a registered output unless o_tok stalls, so sustained rate is one byte
// per cycle. A token passes the queue and the output register before it is
// on o_tok. Output back-pressure fills the queue and then holds off i_rx.
// Line limits are written on i_cfg (index 0 request line, index 1 header
// line), which is always ready; write them only while no bytes are in flight.
module http_request_header_tokenizer #(
    parameter int MAX_LINE = hrt_pkg::HRT_MAX_LINE
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hrt_in_if.sink      i_rx,
    hrt_cfg_if.sink     i_cfg,
    hrt_out_if.source   o_tok
);
    import hrt_pkg::*;

    logic [CFG_W-1:0] r_req_limit;
    logic [CFG_W-1:0] r_hdr_limit;

    t_tok w_push_tok;
    t_tok w_pop_tok;
    logic w_push;
    logic w_full;
    logic w_q_valid;
    logic w_pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_limit <= REQ_LIMIT_RST;
            r_hdr_limit <= HDR_LIMIT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_REQ_LIMIT: r_req_limit <= i_cfg.data;
                REG_HDR_LIMIT: r_hdr_limit <= i_cfg.data;
                default: begin
                    r_req_limit <= r_req_limit;
                end
            endcase
        end
    end

    hrt_front u_front (
        .i_rx     (i_rx),
        .i_q_full (w_full),
        .o_tok    (w_push_tok),
        .o_push   (w_push)
    );

    hrt_queue #(
        .DEPTH (HRT_Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_tok   (w_push_tok),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_tok   (w_pop_tok),
        .i_pop   (w_pop)
    );

    hrt_back #(
        .MAX_LINE (MAX_LINE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_tok     (w_pop_tok),
        .o_q_pop     (w_pop),
        .i_req_limit (r_req_limit),
        .i_hdr_limit (r_hdr_limit),
        .o_tok       (o_tok)
    );

endmodule
`default_nettype wire
